>>> sv/nearest_centroid_assign_assert.svh
// Assertion macros shared by the nearest-centroid checker.
// Needs nothing else; take it in with an include of the bare file name.
`ifndef NEAREST_CENTROID_ASSIGN_ASSERT_SVH
`define NEAREST_CENTROID_ASSIGN_ASSERT_SVH

// Check cons in the same cycle as ante.
`define NCA_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define NCA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/nca_pkg.sv
// Shared widths, codes and stage control type for the nearest-centroid block.
// Depends on nothing; every other file but the assertion macro header imports it.
`default_nettype none

package nca_pkg;

	localparam int VALUE_W   = 16;
	localparam int DIFF_W    = 17;
	localparam int SQ_W      = 32;
	localparam int DIST_W    = 40;
	localparam int SEL_W     = 6;
	localparam int DIM_W     = 8;
	localparam int DIM_SPAN  = 256;
	localparam int AC_W      = 7;
	localparam int AD_W      = 9;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;

	localparam logic [AC_W-1:0] AC_RESET = 7'd64;
	localparam logic [AD_W-1:0] AD_RESET = 9'd256;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_CENTROIDS = 1'b0,
		REG_ACTIVE_DIMS      = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic active;
		logic first;
	} stage_ctl_t;

endpackage

`default_nettype wire

>>> sv/nca_centroid_mem.sv
// Centroid element store: one write port, one read port, registered read.
// Uses nca_pkg for the element width.
`default_nettype none

module nca_centroid_mem #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [AW-1:0]                        waddr,
	input  logic signed [nca_pkg::VALUE_W-1:0]   wdata,
	input  logic [AW-1:0]                        raddr,
	output logic signed [nca_pkg::VALUE_W-1:0]   rdata
);
	import nca_pkg::*;

	logic signed [VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> sv/nca_sum_mem.sv
// Running distance sums: one write port, one read port, registered read.
// Uses nca_pkg for the distance width.
`default_nettype none

module nca_sum_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [nca_pkg::DIST_W-1:0]    wdata,
	input  logic [AW-1:0]                 raddr,
	output logic [nca_pkg::DIST_W-1:0]    rdata
);
	import nca_pkg::*;

	logic [DIST_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> sv/nca_dist_unit.sv
// Per-centroid update: difference, square, accumulate with saturation, write back.
// Uses nca_pkg; fed by the memories' read data and the sequencer's stage tag.
`default_nettype none

module nca_dist_unit #(
	parameter int CW = 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  nca_pkg::stage_ctl_t                  ctl_s1,
	input  logic [CW-1:0]                        idx_s1,
	input  logic signed [nca_pkg::VALUE_W-1:0]   query_val,
	input  logic signed [nca_pkg::VALUE_W-1:0]   cent_val,
	input  logic [nca_pkg::DIST_W-1:0]           sum_old,
	output logic                                 wr_en,
	output logic [CW-1:0]                        wr_addr,
	output logic [nca_pkg::DIST_W-1:0]           wr_data,
	output nca_pkg::stage_ctl_t                  ctl_s3,
	output logic [CW-1:0]                        idx_s3,
	output logic [nca_pkg::DIST_W-1:0]           sum_s3,
	output logic                                 busy
);
	import nca_pkg::*;

	localparam int SUM_W = DIST_W + 1;

	logic signed [DIFF_W-1:0]   diff;
	logic signed [2*DIFF_W-1:0] prod;
	stage_ctl_t                 ctl_s2;
	logic [CW-1:0]              idx_s2;
	logic [SQ_W-1:0]            sq_s2;
	logic [DIST_W-1:0]          old_s2;
	logic [SUM_W-1:0]           sum_wide;
	logic [DIST_W-1:0]          sum_new;

	// Stage 1: square of the element difference (always fits 32 bits).
	assign diff = DIFF_W'(query_val) - DIFF_W'(cent_val);
	assign prod = diff * diff;

	always_ff @(posedge clk) begin
		idx_s2 <= idx_s1;
		sq_s2  <= prod[SQ_W-1:0];
		// Start from zero on element zero of a query.
		old_s2 <= ctl_s1.first ? '0 : sum_old;
	end

	// Stage 2: accumulate, saturate; inactive rows are cleared.
	assign sum_wide = {1'b0, old_s2} + SUM_W'(sq_s2);

	always_comb begin
		if (!ctl_s2.active) begin
			sum_new = '0;
		end else if (sum_wide[DIST_W]) begin
			sum_new = '1;
		end else begin
			sum_new = sum_wide[DIST_W-1:0];
		end
	end

	assign wr_en   = ctl_s2.valid;
	assign wr_addr = idx_s2;
	assign wr_data = sum_new;

	always_ff @(posedge clk) begin
		idx_s3 <= idx_s2;
		sum_s3 <= sum_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	assign busy = ctl_s2.valid | ctl_s3.valid;

endmodule

`default_nettype wire

>>> sv/nearest_centroid_assign.sv
// Nearest-centroid assignment by squared Euclidean distance: top level.
// Uses nca_pkg, nca_centroid_mem, nca_sum_mem and nca_dist_unit.
//
//   channel   handshake                 payload
//   -------   -----------------------   ---------------------------------------------
//   item      item_valid / item_stall   cmd, centroid_sel, dim_index, value
//   result    result_valid / result_stall  nearest_centroid, best_distance
//   config    cfg_we (no wait)          cfg_index, cfg_data
//
// A load word is taken without leaving the idle state; a query word outside the
// active dimensions is dropped the same way. A query word sweeps the N active
// centroids, or all MAX_CENTROIDS rows for element zero to clear them, then
// drains; the sum memory is visited one row a cycle. After reset the sums are
// cleared in a pass over every row while item_stall is high. A waiting result
// does not block the input; only a new result meeting a stalled one holds it.
`default_nettype none

module nearest_centroid_assign #(
	parameter int MAX_CENTROIDS = 64,
	parameter int MAX_DIMS      = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [nca_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [nca_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 cmd,
	input  logic [nca_pkg::SEL_W-1:0]            centroid_sel,
	input  logic [nca_pkg::DIM_W-1:0]            dim_index,
	input  logic signed [nca_pkg::VALUE_W-1:0]   value,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [nca_pkg::SEL_W-1:0]            nearest_centroid,
	output logic [nca_pkg::DIST_W-1:0]           best_distance
);
	import nca_pkg::*;

	localparam int CW      = $clog2(MAX_CENTROIDS);
	localparam int DEPTH   = MAX_CENTROIDS * MAX_DIMS;
	localparam int AW      = $clog2(DEPTH);
	localparam int DIM_CAP = (MAX_DIMS < DIM_SPAN) ? MAX_DIMS : DIM_SPAN;
	localparam logic [CW-1:0] CNT_LAST = CW'(MAX_CENTROIDS - 1);
	localparam logic [AW-1:0] ROW_STEP = AW'(MAX_DIMS);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_SWEEP = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t                    state_q;
	logic [AC_W-1:0]           ac_q;
	logic [AD_W-1:0]           ad_q;
	logic [CW-1:0]             nc_last;
	logic [DIM_W-1:0]          nd_last;
	logic                      accept;
	logic                      load_go;
	logic                      load_ok;
	logic                      query_go;
	logic [AW-1:0]             load_addr;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             sweep_last_q;
	logic [CW-1:0]             nc_last_q;
	logic [AW-1:0]             base_q;
	logic [DIM_W-1:0]          dim_q;
	logic signed [VALUE_W-1:0] val_q;
	logic                      first_q;
	logic                      last_q;
	stage_ctl_t                ctl_s1;
	logic [CW-1:0]             idx_s1;
	logic signed [VALUE_W-1:0] cent_rd;
	logic [DIST_W-1:0]         sum_rd;
	logic                      du_wr_en;
	logic [CW-1:0]             du_wr_addr;
	logic [DIST_W-1:0]         du_wr_data;
	stage_ctl_t                ctl_s3;
	logic [CW-1:0]             idx_s3;
	logic [DIST_W-1:0]         sum_s3;
	logic                      du_busy;
	logic                      sm_we;
	logic [CW-1:0]             sm_waddr;
	logic [DIST_W-1:0]         sm_wdata;
	logic [DIST_W-1:0]         best_q;
	logic [CW-1:0]             best_idx_q;
	logic                      pipe_empty;
	logic                      emit;
	logic                      res_valid_q;
	logic [SEL_W-1:0]          res_idx_q;
	logic [DIST_W-1:0]         res_dist_q;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac_q <= AC_RESET;
			ad_q <= AD_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ACTIVE_CENTROIDS: ac_q <= cfg_data[AC_W-1:0];
				REG_ACTIVE_DIMS:      ad_q <= cfg_data[AD_W-1:0];
			endcase
		end
	end

	// Clamp the registers: zero acts as one, large values act as the ceiling.
	// Dimensions are also capped by what dim_index can address.
	always_comb begin
		if (ac_q == '0) begin
			nc_last = '0;
		end else if (int'(ac_q) > MAX_CENTROIDS) begin
			nc_last = CNT_LAST;
		end else begin
			nc_last = CW'(int'(ac_q) - 1);
		end
		if (ad_q == '0) begin
			nd_last = '0;
		end else if (int'(ad_q) > DIM_CAP) begin
			nd_last = DIM_W'(DIM_CAP - 1);
		end else begin
			nd_last = DIM_W'(int'(ad_q) - 1);
		end
	end

	// ---------------------------------------------------------------
	// Input word decode
	// ---------------------------------------------------------------
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign load_go    = accept && (cmd == CMD_LOAD);
	assign query_go   = accept && (cmd == CMD_QUERY) && (dim_index <= nd_last);

	// Drop loads that fall outside the store.
	assign load_ok   = (int'(centroid_sel) < MAX_CENTROIDS) && (int'(dim_index) < MAX_DIMS);
	assign load_addr = AW'(int'(centroid_sel) * MAX_DIMS + int'(dim_index));

	// ---------------------------------------------------------------
	// Sequencer: clear pass after reset, then one row per cycle per query word.
	// ---------------------------------------------------------------
	assign pipe_empty = !ctl_s1.valid && !du_busy;
	// Emit once the last update has passed the minimum tracker and the
	// output register is free or being emptied this cycle.
	assign emit = (state_q == ST_DRAIN) && pipe_empty && last_q
		&& (!res_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (query_go) begin
						cnt_q   <= '0;
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == sweep_last_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (pipe_empty && (!last_q || emit)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// Capture the query word; base address advances one row per cycle.
	always_ff @(posedge clk) begin
		if (query_go) begin
			val_q     <= value;
			dim_q     <= dim_index;
			first_q   <= (dim_index == '0);
			last_q    <= (dim_index == nd_last);
			nc_last_q <= nc_last;
			// Element zero sweeps every row so that inactive sums clear too.
			sweep_last_q <= (dim_index == '0) ? CNT_LAST : nc_last;
			base_q       <= '0;
		end else if (state_q == ST_SWEEP) begin
			base_q <= base_q + ROW_STEP;
		end
	end

	// Stage tag for the read issued this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid  <= (state_q == ST_SWEEP);
			ctl_s1.active <= (cnt_q <= nc_last_q);
			ctl_s1.first  <= first_q;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
	end

	// ---------------------------------------------------------------
	// Memories and update datapath
	// ---------------------------------------------------------------
	nca_centroid_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_centroid_mem (
		.clk   (clk),
		.we    (load_go && load_ok),
		.waddr (load_addr),
		.wdata (value),
		.raddr (base_q + AW'(dim_q)),
		.rdata (cent_rd)
	);

	// The clear pass owns the write port until the block first goes idle.
	assign sm_we    = (state_q == ST_CLEAR) || du_wr_en;
	assign sm_waddr = (state_q == ST_CLEAR) ? cnt_q : du_wr_addr;
	assign sm_wdata = (state_q == ST_CLEAR) ? '0 : du_wr_data;

	nca_sum_mem #(
		.DEPTH (MAX_CENTROIDS),
		.AW    (CW)
	) u_sum_mem (
		.clk   (clk),
		.we    (sm_we),
		.waddr (sm_waddr),
		.wdata (sm_wdata),
		.raddr (cnt_q),
		.rdata (sum_rd)
	);

	nca_dist_unit #(
		.CW (CW)
	) u_dist_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.idx_s1    (idx_s1),
		.query_val (val_q),
		.cent_val  (cent_rd),
		.sum_old   (sum_rd),
		.wr_en     (du_wr_en),
		.wr_addr   (du_wr_addr),
		.wr_data   (du_wr_data),
		.ctl_s3    (ctl_s3),
		.idx_s3    (idx_s3),
		.sum_s3    (sum_s3),
		.busy      (du_busy)
	);

	// ---------------------------------------------------------------
	// Running minimum: rows arrive in index order, so a strict compare
	// keeps the lowest index on a tie. Row zero restarts the search.
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (ctl_s3.valid && ctl_s3.active && ((idx_s3 == '0) || (sum_s3 < best_q))) begin
			best_q     <= sum_s3;
			best_idx_q <= idx_s3;
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_idx_q  <= SEL_W'(best_idx_q);
			res_dist_q <= best_q;
		end
	end

	assign result_valid     = res_valid_q;
	assign nearest_centroid = res_idx_q;
	assign best_distance    = res_dist_q;

endmodule

`default_nettype wire

>>> sv/nca_checker.sv
// Port-level checks for nearest_centroid_assign, attached by bind.
// Uses nca_pkg and the macros of nearest_centroid_assign_assert.svh.
`default_nettype none

`include "nearest_centroid_assign_assert.svh"

module nca_port_props (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_stall,
	input logic                          cmd,
	input logic [nca_pkg::DIM_W-1:0]     dim_index,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic [nca_pkg::SEL_W-1:0]     nearest_centroid,
	input logic [nca_pkg::DIST_W-1:0]    best_distance
);
	import nca_pkg::*;

	logic load_acc;
	logic first_acc;

	assign load_acc  = item_valid && !item_stall && (cmd == CMD_LOAD);
	assign first_acc = item_valid && !item_stall && (cmd == CMD_QUERY) && (dim_index == '0);

	// A load word never holds the input past its own cycle.
	`NCA_ASSERT_NEXT(a_load_single_cycle, clk, arst_n, load_acc, !item_stall, "load word stalled input")

	// Element zero always starts a sweep.
	`NCA_ASSERT_NEXT(a_first_starts_sweep, clk, arst_n, first_acc, item_stall, "element zero not swept")

	// A new result only appears at the end of a sweep.
	`NCA_ASSERT_SAME(a_result_after_sweep, clk, arst_n, $rose(result_valid), $past(item_stall), "result without sweep")

	// A stalled result holds.
	`NCA_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(nearest_centroid) && $stable(best_distance), "stalled result changed")

endmodule

bind nearest_centroid_assign nca_port_props u_nca_port_props (.*);

`default_nettype wire

>>> dv/nca_checker.sv
`timescale 1ns / 1ps
// Scoreboard for nearest_centroid_assign: watches the config port and both channels,
// keeps its own centroid rows and running distances, and checks every result word.
// Depends on nca_pkg only.
module nca_checker #(
	parameter int MAX_CENTROIDS = 64,
	parameter int MAX_DIMS      = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [nca_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [nca_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 item_valid,
	input  logic                                 item_stall,
	input  logic                                 cmd,
	input  logic [nca_pkg::SEL_W-1:0]            centroid_sel,
	input  logic [nca_pkg::DIM_W-1:0]            dim_index,
	input  logic signed [nca_pkg::VALUE_W-1:0]   value,
	input  logic                                 result_valid,
	input  logic                                 result_stall,
	input  logic [nca_pkg::SEL_W-1:0]            nearest_centroid,
	input  logic [nca_pkg::DIST_W-1:0]           best_distance,
	output int                                   fail_count,
	output int                                   pending
);
	import nca_pkg::*;

	localparam logic [DIST_W-1:0] DIST_SAT = '1;

	typedef struct packed {
		logic [SEL_W-1:0]  row;
		logic [DIST_W-1:0] distance;
	} assignment_t;

	logic signed [VALUE_W-1:0] row_elems [MAX_CENTROIDS][MAX_DIMS];
	logic [DIST_W-1:0]         run_dist [MAX_CENTROIDS];
	logic [AC_W-1:0]           centroids_reg = AC_RESET;
	logic [AD_W-1:0]           dims_reg = AD_RESET;
	assignment_t               expected_assign [$];
	int                        mismatch_total = 0;

	function automatic int live_centroids();
		if (centroids_reg == 0) return 1;
		if (centroids_reg > MAX_CENTROIDS) return MAX_CENTROIDS;
		return centroids_reg;
	endfunction

	function automatic int live_dims();
		int n;
		n = dims_reg;
		if (n == 0) n = 1;
		if (n > MAX_DIMS) n = MAX_DIMS;
		if (n > DIM_SPAN) n = DIM_SPAN;
		return n;
	endfunction

	// Add one query element to every live row; at the last live dim, queue the winner.
	task automatic take_query(input logic [DIM_W-1:0] dim, input logic signed [VALUE_W-1:0] elem);
		int nc;
		int nd;
		logic signed [DIFF_W-1:0] diff;
		logic [DIFF_W-1:0] mag;
		logic [2*DIFF_W-1:0] sq;
		logic [DIST_W:0] acc;
		assignment_t found;
		nc = live_centroids();
		nd = live_dims();
		if (dim >= nd) return;
		if (dim == 0) begin
			for (int c = 0; c < MAX_CENTROIDS; c++) run_dist[c] = '0;
		end
		for (int c = 0; c < nc; c++) begin
			diff = elem - row_elems[c][dim];
			mag = diff[DIFF_W-1] ? -diff : diff;
			sq = mag * mag;
			acc = run_dist[c] + sq;
			run_dist[c] = (acc > DIST_SAT) ? DIST_SAT : acc[DIST_W-1:0];
		end
		if (dim != nd - 1) return;
		found.row = '0;
		found.distance = run_dist[0];
		for (int c = 1; c < nc; c++) begin
			if (run_dist[c] < found.distance) begin
				found.distance = run_dist[c];
				found.row = SEL_W'(c);
			end
		end
		expected_assign.insert(expected_assign.size(), found);
	endtask

	task automatic check_assignment();
		assignment_t want;
		if (expected_assign.size() == 0) begin
			$error("result word with nothing pending: nearest_centroid %0d, best_distance %0d",
				nearest_centroid, best_distance);
			mismatch_total++;
			return;
		end
		want = expected_assign.pop_front();
		if (nearest_centroid !== want.row) begin
			$error("nearest_centroid: expected %0d, got %0d", want.row, nearest_centroid);
			mismatch_total++;
		end
		if (best_distance !== want.distance) begin
			$error("best_distance: expected %0d, got %0d", want.distance, best_distance);
			mismatch_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centroids_reg = AC_RESET;
			dims_reg = AD_RESET;
			for (int c = 0; c < MAX_CENTROIDS; c++) run_dist[c] = '0;
			expected_assign.delete();
			pending <= 0;
			fail_count <= mismatch_total;
		end else begin
			// retire results first: a word accepted now cannot answer itself
			if (result_valid && !result_stall) check_assignment();
			if (cfg_we) begin
				if (cfg_index == REG_ACTIVE_CENTROIDS) centroids_reg = cfg_data[AC_W-1:0];
				else dims_reg = cfg_data[AD_W-1:0];
			end
			if (item_valid && !item_stall) begin
				if (cmd == CMD_LOAD) row_elems[centroid_sel][dim_index] = value;
				else take_query(dim_index, value);
			end
			pending <= expected_assign.size();
			fail_count <= mismatch_total;
		end
	end

endmodule

>>> dv/nearest_centroid_assign_tb.sv
`timescale 1ns / 1ps
// Top of the nearest_centroid_assign testbench: clock, reset, stimulus and verdict.
// Depends on nca_pkg, the block itself and nca_checker (dv/nca_checker.sv).
module nearest_centroid_assign_tb;
	import nca_pkg::*;

	localparam int MAX_CENTROIDS = 64;
	localparam int MAX_DIMS      = 256;
	// longest quiet time a dropped or in-flight query word can need, clear pass included
	localparam int SETTLE        = 2 * MAX_CENTROIDS + 16;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_WORDS   = 100;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	reg_idx_t                     cfg_index = REG_ACTIVE_CENTROIDS;
	logic [CFG_W-1:0]             cfg_data = '0;
	logic                         item_valid = 1'b0;
	logic                         item_stall;
	logic                         cmd = CMD_LOAD;
	logic [SEL_W-1:0]             centroid_sel = '0;
	logic [DIM_W-1:0]             dim_index = '0;
	logic signed [VALUE_W-1:0]    value = '0;
	logic                         result_valid;
	logic                         result_stall = 1'b0;
	logic [SEL_W-1:0]             nearest_centroid;
	logic [DIST_W-1:0]            best_distance;
	int                           fail_count;
	int                           pending;

	idle_mode_t                   idle_mode = IDLE_NONE;
	int unsigned                  cycles = 0;
	int                           words_taken = 0;

	// What the stimulus has loaded so far, so no query ever reads an unwritten element,
	// and so queries can be aimed close to a chosen row.
	bit                           loaded [MAX_CENTROIDS][MAX_DIMS];
	logic signed [VALUE_W-1:0]    loaded_val [MAX_CENTROIDS][MAX_DIMS];
	logic [AC_W-1:0]              ac_raw = AC_RESET;
	logic [AD_W-1:0]              ad_raw = AD_RESET;

	nearest_centroid_assign #(
		.MAX_CENTROIDS(MAX_CENTROIDS),
		.MAX_DIMS(MAX_DIMS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.cmd(cmd),
		.centroid_sel(centroid_sel),
		.dim_index(dim_index),
		.value(value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.nearest_centroid(nearest_centroid),
		.best_distance(best_distance)
	);

	nca_checker #(
		.MAX_CENTROIDS(MAX_CENTROIDS),
		.MAX_DIMS(MAX_DIMS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.cmd(cmd),
		.centroid_sel(centroid_sel),
		.dim_index(dim_index),
		.value(value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.nearest_centroid(nearest_centroid),
		.best_distance(best_distance),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #5 clk = ~clk;

	// Receiver side: stall at the rate of the current idle mode, never in IDLE_NONE.
	always @(posedge clk) begin
		case (idle_mode)
			IDLE_RECEIVER: begin
				result_stall <= ($urandom_range(0, 99) < 73);
			end
			IDLE_BOTH: begin
				result_stall <= ($urandom_range(0, 99) < 13);
			end
			default: begin
				result_stall <= 1'b0;
			end
		endcase
	end

	// Watchdog: a hung handshake or a lost result ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("nearest_centroid_assign_tb: done, errors");
			$finish;
		end
	end

	function automatic int eff_nc();
		if (ac_raw == 0) return 1;
		if (ac_raw > MAX_CENTROIDS) return MAX_CENTROIDS;
		return ac_raw;
	endfunction

	function automatic int eff_nd();
		if (ad_raw == 0) return 1;
		if (ad_raw > MAX_DIMS) return MAX_DIMS;
		return ad_raw;
	endfunction

	function automatic logic signed [VALUE_W-1:0] any_value();
		logic [31:0] r;
		r = $urandom;
		return r[VALUE_W-1:0];
	endfunction

	// Query element for dim d, aimed at the given row: near it or random, sometimes on it
	// exactly (zero distance, ties with copied rows), sometimes at the extremes.
	function automatic logic signed [VALUE_W-1:0] probe_value(int row, int d);
		int pick;
		int near;
		pick = $urandom_range(0, 99);
		if (pick < 35) return any_value();
		if (pick < 45) return loaded_val[row][d];
		if (pick < 65) begin
			case ($urandom_range(0, 3))
				0: return -16'sd32768;
				1: return 16'sd32767;
				2: return 16'sd0;
				default: return -16'sd1;
			endcase
		end
		near = loaded_val[row][d];
		near = near + int'($urandom_range(0, 512)) - 256;
		if (near > 32767) near = 32767;
		if (near < -32768) near = -32768;
		return near[VALUE_W-1:0];
	endfunction

	// Offer one word; return once it has been taken. Gaps go in front of the word,
	// so valid never waits on stall and a stalled word holds still.
	task automatic send_word(input logic c, input logic [SEL_W-1:0] sel,
			input logic [DIM_W-1:0] dim, input logic signed [VALUE_W-1:0] v);
		int gap_pct;
		gap_pct = (idle_mode == IDLE_SENDER) ? 73 : (idle_mode == IDLE_BOTH) ? 13 : 0;
		while ($urandom_range(0, 99) < gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		cmd <= c;
		centroid_sel <= sel;
		dim_index <= dim;
		value <= v;
		if (c == CMD_LOAD) begin
			loaded[sel][dim] = 1'b1;
			loaded_val[sel][dim] = v;
		end
		if (c == CMD_LOAD || dim < eff_nd()) words_taken++;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic load_word(input int sel, input int dim, input logic signed [VALUE_W-1:0] v);
		send_word(CMD_LOAD, SEL_W'(sel), DIM_W'(dim), v);
	endtask

	// centroid_sel means nothing on a query, so let it wander
	task automatic query_word(input int dim, input logic signed [VALUE_W-1:0] v);
		send_word(CMD_QUERY, SEL_W'($urandom_range(0, MAX_CENTROIDS - 1)), DIM_W'(dim), v);
	endtask

	// Load every live row's element at dim d that has not been written yet. Some rows
	// copy their neighbor, which makes equal distances and so ties.
	task automatic load_missing_column(input int d);
		logic signed [VALUE_W-1:0] v;
		for (int c = 0; c < eff_nc(); c++) begin
			if (!loaded[c][d]) begin
				if (c > 0 && $urandom_range(0, 4) == 0) v = loaded_val[c-1][d];
				else v = any_value();
				load_word(c, d, v);
			end
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input int data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[CFG_W-1:0];
		if (idx == REG_ACTIVE_CENTROIDS) ac_raw = data[AC_W-1:0];
		else ad_raw = data[AD_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Hold the input until every predicted result has been taken.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Drain, then let a word that makes no result run out before touching registers.
	task automatic quiesce();
		drain();
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		int start;
		int pick;
		int target;
		int stop_at;
		bit held;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// the block clears its sums after reset; stay off the config port meanwhile
		repeat (SETTLE) @(posedge clk);

		// Directed: three rows over two dims. Row 0 sits at the opposite corners,
		// rows 1 and 2 are equal so every query ties between them.
		write_reg(REG_ACTIVE_CENTROIDS, 3);
		write_reg(REG_ACTIVE_DIMS, 2);
		load_word(0, 0, -16'sd32768);
		load_word(0, 1, 16'sd32767);
		load_word(1, 0, 16'sd0);
		load_word(1, 1, 16'sd0);
		load_word(2, 0, 16'sd0);
		load_word(2, 1, 16'sd0);
		query_word(0, 16'sd0);
		query_word(1, 16'sd0);           // zero distance tie, lower row wins
		query_word(0, 16'sd32767);
		query_word(1, -16'sd32768);      // widest possible difference against row 0
		query_word(5, 16'sh1234);        // beyond the live dims: dropped
		query_word(255, -16'sd1);
		query_word(1, 16'sd100);         // last dim again without element zero first
		load_word(63, 255, 16'sh5555);   // far corner of the store
		load_word(0, 0, 16'sd0);
		query_word(1, 16'sd32767);       // reversed order
		query_word(0, 16'sd0);
		// Grow the live rows in the middle of a vector: rows 1 and 2 keep the sums
		// that element zero left them.
		quiesce();
		write_reg(REG_ACTIVE_CENTROIDS, 1);
		query_word(0, 16'sd7);
		quiesce();
		write_reg(REG_ACTIVE_CENTROIDS, 3);
		query_word(1, -16'sd7);

		// Full width: one row at the bottom of the range, a query at the top over
		// every dim gives the largest distance there is. Out-of-range settings clamp.
		quiesce();
		idle_mode = IDLE_SENDER;
		write_reg(REG_ACTIVE_CENTROIDS, 0);
		write_reg(REG_ACTIVE_DIMS, 9'd511);
		for (int d = 0; d < MAX_DIMS; d++) load_word(0, d, -16'sd32768);
		for (int d = 0; d < MAX_DIMS; d++) query_word(d, 16'sd32767);

		// Keep adding at the last dim without clearing until the sum saturates.
		quiesce();
		idle_mode = IDLE_RECEIVER;
		write_reg(REG_ACTIVE_DIMS, 2);
		query_word(0, 16'sd32767);
		repeat (260) query_word(1, 16'sd32767);

		// Every row live, one dim: each query element is a whole vector.
		quiesce();
		idle_mode = IDLE_BOTH;
		write_reg(REG_ACTIVE_CENTROIDS, 9'h17F);
		write_reg(REG_ACTIVE_DIMS, 0);
		load_missing_column(0);
		repeat (80) begin
			query_word(0, probe_value($urandom_range(0, MAX_CENTROIDS - 1), 0));
			if ($urandom_range(0, 7) == 0) query_word($urandom_range(1, 255), any_value());
		end

		// Random phases: mostly whole vectors with random content, the rest stray
		// loads, dropped dims, aborted vectors and elements out of order.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			quiesce();
			idle_mode = idle_mode_t'(p % 4);
			case (p)
				0: begin
					write_reg(REG_ACTIVE_CENTROIDS, 1);
					write_reg(REG_ACTIVE_DIMS, $urandom_range(1, 6));
				end
				1: begin
					write_reg(REG_ACTIVE_CENTROIDS, MAX_CENTROIDS);
					write_reg(REG_ACTIVE_DIMS, 3);
				end
				2: begin
					write_reg(REG_ACTIVE_DIMS, 12);
					write_reg(REG_ACTIVE_CENTROIDS, 2);
				end
				default: begin
					write_reg(REG_ACTIVE_CENTROIDS, $urandom_range(2, 16));
					write_reg(REG_ACTIVE_DIMS, $urandom_range(1, 8));
				end
			endcase
			start = words_taken;
			held = 1'b0;
			while (words_taken - start < PHASE_WORDS) begin
				// once per phase, hold off until the block has delivered everything
				if (!held && words_taken - start > PHASE_WORDS / 2) begin
					drain();
					held = 1'b1;
				end
				pick = $urandom_range(0, 99);
				target = $urandom_range(0, eff_nc() - 1);
				if (pick < 75) begin
					stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, eff_nd() - 1)
						: eff_nd();
					for (int d = 0; d < stop_at; d++) begin
						load_missing_column(d);
						query_word(d, probe_value(target, d));
					end
				end else if (pick < 85 || eff_nd() >= DIM_SPAN) begin
					load_word($urandom_range(0, MAX_CENTROIDS - 1), $urandom_range(0, 255),
						any_value());
				end else if (pick < 92) begin
					query_word($urandom_range(eff_nd(), 255), any_value());
				end else begin
					stop_at = $urandom_range(0, eff_nd() - 1);
					load_missing_column(stop_at);
					query_word(stop_at, probe_value(target, stop_at));
				end
			end
		end

		quiesce();
		if (fail_count == 0) begin
			$display("nearest_centroid_assign_tb: done, clean");
		end else begin
			$display("nearest_centroid_assign_tb: done, errors");
		end
		$finish;
	end

endmodule
